// File: sv/indexed_list_store_macros.svh
// Assertion macros shared by the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ILS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ils_pkg.sv
// Types and constants of the indexed list store.
package ils_pkg;

	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int OP_W       = 3;
	localparam int IDX_W      = 9;

	// Stream payload layout
	localparam int IN_BITS    = OP_W + IDX_W + DATA_WIDTH;
	localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 1 + DATA_WIDTH + IDX_W;
	localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD    = M_TDATA_W - OUT_BITS;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_READ   = 3'd3,
		OP_WRITE  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DRAIN,
		ST_PLACE,
		ST_DONE
	} state_t;

endpackage

// File: sv/ils_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/indexed_list_store.sv
// Indexed list store: bounded ordered sequence of signed values in one RAM.
// Append, write, read and failed operations need no shift; insert and remove shift the entries
// behind the index (remove needs none when it takes the last entry), and insert then places
// the new value. Throughput: one item at a time; shifts move one entry per cycle.
// Reset clears the count and the handshake state; RAM contents stay undefined until written.
`include "indexed_list_store_macros.svh"

module indexed_list_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] op, [11:3] index, [43:12] value, [47:44] zero
	input  logic [ils_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] ok, [32:1] read_value, [41:33] count, [47:42] zero
	output logic [ils_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int AW = ils_pkg::ADDR_W;
	localparam int CW = ils_pkg::CNT_W;
	localparam int DW = ils_pkg::DATA_WIDTH;
	localparam int IW = ils_pkg::IDX_W;

	ils_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	ils_pkg::op_t  op_q;
	logic [IW-1:0] idx_q;
	logic [DW-1:0] val_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] rem_q;
	logic          ok_q;
	logic          rd_q;
	logic          rvalid_s1;
	logic [AW-1:0] waddr_s1;

	logic          out_valid_q;
	logic          ok_out_q;
	logic [DW-1:0] rdv_q;
	logic [IW-1:0] cnt_out_q;

	// Input fields
	ils_pkg::op_t  in_op;
	logic [IW-1:0] in_idx;
	logic [DW-1:0] in_val;
	logic          accept;

	// Decode results
	logic          full;
	logic [IW-1:0] put_pos;
	logic          ok_c;
	logic [CW-1:0] cnt_c;
	logic [CW-1:0] ptr_c;
	logic [CW-1:0] rem_c;
	logic          out_load;

	// RAM port controls
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	assign in_op    = ils_pkg::op_t'(s_tdata[ils_pkg::OP_W-1:0]);
	assign in_idx   = s_tdata[ils_pkg::OP_W +: IW];
	assign in_val   = s_tdata[ils_pkg::OP_W + IW +: DW];
	assign s_tready = (state_q == ils_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (cnt_q == CW'(ils_pkg::CAPACITY));
	assign put_pos  = (in_op == ils_pkg::OP_APPEND) ? IW'(cnt_q) : in_idx;
	assign out_load = (state_q == ils_pkg::ST_DONE) && (!out_valid_q || m_tready);

	ils_ram #(
		.WIDTH(DW),
		.DEPTH(ils_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next state, RAM accesses and decode of the accepted operation
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = put_pos[AW-1:0];
		ram_wdata = in_val;
		ram_re    = 1'b0;
		ram_raddr = in_idx[AW-1:0];
		ok_c      = 1'b0;
		cnt_c     = cnt_q;
		ptr_c     = cnt_q - CW'(1);
		rem_c     = cnt_q - CW'(put_pos);

		// Write back the entry read in the previous shift step
		if (rvalid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = ram_rdata;
		end

		case (state_q)
			ils_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ils_pkg::ST_DONE;
					case (in_op)
						ils_pkg::OP_APPEND, ils_pkg::OP_INSERT: begin
							if (!full && CW'(put_pos) <= cnt_q) begin
								ok_c  = 1'b1;
								cnt_c = cnt_q + CW'(1);
								if (CW'(put_pos) == cnt_q) begin
									ram_we = 1'b1;
								end else begin
									state_d = ils_pkg::ST_SHIFT;
								end
							end
						end
						ils_pkg::OP_REMOVE: begin
							ptr_c = CW'(in_idx) + CW'(1);
							rem_c = cnt_q - CW'(in_idx) - CW'(1);
							if (CW'(in_idx) < cnt_q) begin
								ok_c  = 1'b1;
								cnt_c = cnt_q - CW'(1);
								if (rem_c != '0) begin
									state_d = ils_pkg::ST_SHIFT;
								end
							end
						end
						ils_pkg::OP_READ: begin
							if (CW'(in_idx) < cnt_q) begin
								ok_c   = 1'b1;
								ram_re = 1'b1;
							end
						end
						ils_pkg::OP_WRITE: begin
							ram_waddr = in_idx[AW-1:0];
							if (CW'(in_idx) < cnt_q) begin
								ok_c   = 1'b1;
								ram_we = 1'b1;
							end
						end
						default: begin
							ok_c = 1'b0;
						end
					endcase
				end
			end
			ils_pkg::ST_SHIFT: begin
				ram_re    = 1'b1;
				ram_raddr = ptr_q[AW-1:0];
				if (rem_q == CW'(1)) begin
					state_d = ils_pkg::ST_DRAIN;
				end
			end
			ils_pkg::ST_DRAIN: begin
				state_d = (op_q == ils_pkg::OP_REMOVE) ? ils_pkg::ST_DONE : ils_pkg::ST_PLACE;
			end
			ils_pkg::ST_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = val_q;
				state_d   = ils_pkg::ST_DONE;
			end
			ils_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = ils_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ils_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ils_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count and pending write-back flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= (state_q == ils_pkg::ST_SHIFT);
			if (accept) begin
				cnt_q <= cnt_c;
			end
		end
	end

	// Operation context and shift walk
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			idx_q <= put_pos;
			val_q <= in_val;
			ok_q  <= ok_c;
			rd_q  <= ok_c && (in_op == ils_pkg::OP_READ);
			ptr_q <= ptr_c;
			rem_q <= rem_c;
		end else if (state_q == ils_pkg::ST_SHIFT) begin
			rem_q <= rem_q - CW'(1);
			if (op_q == ils_pkg::OP_REMOVE) begin
				ptr_q    <= ptr_q + CW'(1);
				waddr_s1 <= AW'(ptr_q - CW'(1));
			end else begin
				ptr_q    <= ptr_q - CW'(1);
				waddr_s1 <= AW'(ptr_q + CW'(1));
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, held until its transfer
	always_ff @(posedge clk) begin
		if (out_load) begin
			ok_out_q  <= ok_q;
			rdv_q     <= rd_q ? ram_rdata : '0;
			cnt_out_q <= IW'(cnt_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{ils_pkg::OUT_PAD{1'b0}}, cnt_out_q, rdv_q, ok_out_q};

	`ILS_ASSERT(a_cnt_bound, cnt_q <= CW'(ils_pkg::CAPACITY), "count above capacity")
	`ILS_ASSERT(a_shift_rem, (state_q == ils_pkg::ST_SHIFT) |-> (rem_q != '0), "empty shift")
	`ILS_ASSERT(a_idle_drained, s_tready |-> !rvalid_s1, "input taken with a write-back pending")
	`ILS_ASSERT_NEXT(a_done_loads, out_load, m_tvalid && (state_q == ils_pkg::ST_IDLE), "no result")

endmodule

// File: tb/indexed_list_store_tb.sv
// Testbench for the indexed list store: operation stream checked against a shadow list.
module indexed_list_store_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Op codes the block decodes as no-ops
	localparam logic [ils_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [ils_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	localparam int DW = ils_pkg::DATA_WIDTH;
	localparam int IW = ils_pkg::IDX_W;
	localparam int OW = ils_pkg::OP_W;

	localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam int IDX_TOP = (1 << IW) - 1;

	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 150;
	localparam int RANDOM_OPS  = 925;

	typedef struct {
		logic          ok;
		logic [DW-1:0] rd;
		logic [IW-1:0] count;
	} reply_t;

	// Shadow copy of the list plus the replies still owed by the block
	class list_tracker;
		logic [DW-1:0] shadow_mem [ils_pkg::CAPACITY];
		int unsigned   shadow_count;
		reply_t        replies_due[$];
		int unsigned   mismatches;

		function new();
			foreach (shadow_mem[i]) shadow_mem[i] = '0;
			shadow_count = 0;
			mismatches = 0;
		endfunction

		// Apply one accepted operation and queue the reply it earns
		function void take_op(logic [OW-1:0] op, logic [IW-1:0] idx, logic [DW-1:0] val);
			reply_t r;
			int unsigned pos;
			r.ok = 1'b0;
			r.rd = '0;
			pos = (op == ils_pkg::OP_APPEND) ? shadow_count : int'(idx);
			case (op)
			ils_pkg::OP_APPEND, ils_pkg::OP_INSERT: begin
				// shift the tail up one slot, then drop the new value in
				if (shadow_count < ils_pkg::CAPACITY && pos <= shadow_count) begin
					for (int unsigned i = shadow_count; i > pos; i--)
						shadow_mem[i] = shadow_mem[i-1];
					shadow_mem[pos] = val;
					shadow_count++;
					r.ok = 1'b1;
				end
			end
			ils_pkg::OP_REMOVE: begin
				// close the gap by moving the tail down one slot
				if (pos < shadow_count) begin
					for (int unsigned i = pos; i + 1 < shadow_count; i++)
						shadow_mem[i] = shadow_mem[i+1];
					shadow_mem[shadow_count-1] = '0;
					shadow_count--;
					r.ok = 1'b1;
				end
			end
			ils_pkg::OP_READ: begin
				if (pos < shadow_count) begin
					r.rd = shadow_mem[pos];
					r.ok = 1'b1;
				end
			end
			ils_pkg::OP_WRITE: begin
				if (pos < shadow_count) begin
					shadow_mem[pos] = val;
					r.ok = 1'b1;
				end
			end
			default: ;
			endcase
			r.count = IW'(shadow_count);
			replies_due.push_back(r);
		endfunction

		// Compare one result transfer against the oldest owed reply
		function void check_reply(logic [ils_pkg::M_TDATA_W-1:0] data);
			reply_t want;
			logic got_ok;
			logic [DW-1:0] got_rd;
			logic [IW-1:0] got_count;
			got_ok = data[0];
			got_rd = data[DW:1];
			got_count = data[DW+IW:DW+1];
			if (replies_due.size() == 0) begin
				$error("result with none owed: ok %0b read_value %0d count %0d",
					got_ok, $signed(got_rd), got_count);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			if (got_ok !== want.ok) begin
				$error("ok: expected %0b, got %0b", want.ok, got_ok);
				mismatches++;
			end
			if (got_rd !== want.rd) begin
				$error("read_value: expected %0d, got %0d", $signed(want.rd), $signed(got_rd));
				mismatches++;
			end
			if (got_count !== want.count) begin
				$error("count: expected %0d, got %0d", want.count, got_count);
				mismatches++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	wire                           s_tready;
	logic [ils_pkg::S_TDATA_W-1:0] s_tdata = '0;
	wire                           m_tvalid;
	logic                          m_tready = 1'b0;
	wire  [ils_pkg::M_TDATA_W-1:0] m_tdata;

	list_tracker tracker = new();
	int unsigned results_seen = 0;

	indexed_list_store u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one operation, wait for its transfer, then maybe leave a gap
	task automatic send_op(input logic [OW-1:0] op, input logic [IW-1:0] idx,
			input logic [DW-1:0] val);
		int unsigned r;
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= ils_pkg::S_TDATA_W'({val, idx, op});
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.take_op(op, idx, val);
		r = $urandom_range(0, 99);
		gap = (r < 70) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random operations: fill the list until it has been found full six times, then drain it, repeat
	task automatic random_ops(input int unsigned n);
		bit growing;
		int unsigned full_hits;
		int unsigned r;
		int unsigned cnt;
		logic [OW-1:0] op;
		logic [IW-1:0] idx;
		logic [DW-1:0] val;
		growing = 1'b1;
		full_hits = 0;
		for (int unsigned k = 0; k < n; k++) begin
			cnt = tracker.shadow_count;
			if (growing && cnt == ils_pkg::CAPACITY)
				full_hits++;
			if (growing && full_hits >= 6) begin
				growing = 1'b0;
				full_hits = 0;
			end else if (!growing && cnt == 0) begin
				growing = 1'b1;
			end

			r = $urandom_range(0, 99);
			if (r >= 97)
				op = OW'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
			else if (growing)
				op = (r < 45) ? ils_pkg::OP_APPEND : (r < 75) ? ils_pkg::OP_INSERT :
					(r < 83) ? ils_pkg::OP_REMOVE : (r < 91) ? ils_pkg::OP_READ :
					ils_pkg::OP_WRITE;
			else
				op = (r < 68) ? ils_pkg::OP_REMOVE : (r < 73) ? ils_pkg::OP_APPEND :
					(r < 78) ? ils_pkg::OP_INSERT : (r < 88) ? ils_pkg::OP_READ :
					ils_pkg::OP_WRITE;

			// mostly legal positions, with edges and out-of-range noise mixed in
			r = $urandom_range(0, 99);
			if (r < 8)
				idx = IW'($urandom_range(0, IDX_TOP));
			else if (r < 16)
				idx = '0;
			else if (r < 24)
				idx = (op == ils_pkg::OP_INSERT || cnt == 0) ? IW'(cnt) : IW'(cnt - 1);
			else if (op == ils_pkg::OP_INSERT)
				idx = IW'($urandom_range(0, cnt));
			else
				idx = (cnt == 0) ? '0 : IW'($urandom_range(0, cnt - 1));

			r = $urandom_range(0, 99);
			if (r < 12) begin
				case ($urandom_range(0, 3))
				0: val = VAL_MIN;
				1: val = VAL_MAX;
				2: val = '0;
				default: val = '1;
				endcase
			end else begin
				val = DW'($urandom);
			end
			send_op(op, idx, val);
		end
	endtask

	// Stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list rejects everything positional
		send_op(ils_pkg::OP_READ, '0, '0);
		send_op(ils_pkg::OP_REMOVE, '0, '0);
		send_op(ils_pkg::OP_WRITE, '0, VAL_MAX);
		// grow with extreme values, insert at front, at the end and past the end
		send_op(ils_pkg::OP_APPEND, '0, VAL_MIN);
		send_op(ils_pkg::OP_APPEND, '0, VAL_MAX);
		send_op(ils_pkg::OP_INSERT, '0, '1);
		send_op(ils_pkg::OP_INSERT, IW'(3), '0);
		send_op(ils_pkg::OP_INSERT, IW'(5), VAL_MAX);
		send_op(ils_pkg::OP_INSERT, IW'(IDX_TOP), '1);
		send_op(ils_pkg::OP_READ, '0, '0);
		send_op(ils_pkg::OP_READ, IW'(1), '0);
		send_op(ils_pkg::OP_READ, IW'(2), '0);
		send_op(ils_pkg::OP_READ, IW'(3), '0);
		send_op(ils_pkg::OP_READ, IW'(4), '0);
		send_op(ils_pkg::OP_WRITE, IW'(1), 32'h1234_5678);
		send_op(ils_pkg::OP_READ, IW'(1), '1);
		// remove from the front and from the end, then one past the end
		send_op(ils_pkg::OP_REMOVE, '0, '1);
		send_op(ils_pkg::OP_REMOVE, IW'(2), '0);
		send_op(ils_pkg::OP_REMOVE, IW'(2), '0);
		// unused codes change nothing
		send_op(OP_SPARE_FIRST, IW'(IDX_TOP), '1);
		send_op(OW'(OP_SPARE_FIRST + 1), '0, VAL_MIN);
		send_op(OP_SPARE_LAST, IW'(1), '1);
		send_op(ils_pkg::OP_READ, IW'(IDX_TOP), '0);
		send_op(ils_pkg::OP_WRITE, IW'(ils_pkg::CAPACITY), '1);
		send_op(ils_pkg::OP_READ, '0, '0);

		random_ops(RANDOM_OPS);
		s_tvalid <= 1'b0;

		while (tracker.replies_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side: random ready, plus one long hold-off to back up the input
	initial begin
		int unsigned r;
		int unsigned span;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
			end else begin
				r = $urandom_range(0, 99);
				span = (r >= 93) ? $urandom_range(20, 80) : $urandom_range(1, 30);
				repeat (span) begin
					@(posedge clk);
					if (r < 35)
						m_tready <= 1'b1;
					else if (r < 75)
						m_tready <= 1'($urandom_range(0, 1));
					else
						m_tready <= 1'b0;
				end
			end
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			tracker.check_reply(m_tdata);
		end
	end

	// Abort when no transfer happens on either side for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule
